// ===== rtl/core/insertion_sort_engine_core_assert.svh =====
// ---------------------------------------------------------------------------
// insertion_sort_engine_core assertion macros
// Clocked property checks used by the checker file.
// ---------------------------------------------------------------------------
`ifndef INSERTION_SORT_ENGINE_CORE_ASSERT_SVH
`define INSERTION_SORT_ENGINE_CORE_ASSERT_SVH

// check while out of reset
`define ISE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check in and out of reset
`define ISE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/ise_pkg.sv =====
// ---------------------------------------------------------------------------
// ise_pkg
// Types and constants of the insertion sort engine.
// ---------------------------------------------------------------------------
`default_nettype none

package ise_pkg;

  localparam int VALUE_W       = 32;
  localparam int ISE_MAX_ITEMS = 16;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last_in;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      last_out;
    logic                      overflow;
  } out_word_t;

  typedef struct packed {
    logic                      ins_en;
    logic                      shift_en;
    logic signed [VALUE_W-1:0] ins_value;
  } cell_ctrl_t;

  typedef enum logic {
    SORT_LOAD,
    SORT_DRAIN
  } sort_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/ise_cell.sv =====
// ---------------------------------------------------------------------------
// ise_cell
// One slot of the insertion chain: holds one value, opens a gap on insert
// and hands its value to the left neighbour on drain.
// ---------------------------------------------------------------------------
`default_nettype none

module ise_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ise_pkg::cell_ctrl_t               ctrl,
  input  logic                              left_valid,
  input  logic                              left_grt,
  input  logic signed [ise_pkg::VALUE_W-1:0] left_value,
  input  logic                              right_valid,
  input  logic signed [ise_pkg::VALUE_W-1:0] right_value,
  output logic signed [ise_pkg::VALUE_W-1:0] cell_value,
  output logic                              cell_valid,
  output logic                              cell_grt
);

  logic signed [ise_pkg::VALUE_W-1:0] value_r;
  logic signed [ise_pkg::VALUE_W-1:0] value_nxt;
  logic                              valid_r;
  logic                              valid_nxt;

  // empty slots count as greater, so the gap lands after the last valid one
  assign cell_grt   = !valid_r || (value_r > ctrl.ins_value);
  assign cell_value = value_r;
  assign cell_valid = valid_r;

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctrl.shift_en) begin
      value_nxt = right_value;
      valid_nxt = right_valid;
    end else if (ctrl.ins_en && cell_grt) begin
      value_nxt = left_grt ? left_value : ctrl.ins_value;
      valid_nxt = valid_r | left_valid;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/insertion_sort_engine_core.sv =====
// ---------------------------------------------------------------------------
// insertion_sort_engine_core
// Stable ascending sorter for sets of signed 32-bit values.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one word per cycle while in_stall is low, value plus last_in
//           marking the end of a set. Each word is inserted into a chain of
//           MAX_ITEMS cells when accepted, after any equal values already held.
//   out_* : after the last word of a set, the chain drains from its head, one
//           word per cycle while not stalled, ascending; last_out marks the
//           final word; overflow is set on every word of a set that lost values.
//   After the last word is accepted, the state register turns to drain and
//   the output register then loads the first result; a set of N stored
//   values drains through the output register, one chain shift per delivered
//   word. in_stall is high for the whole drain. Words beyond MAX_ITEMS are
//   taken and dropped.
//   out_stall holds the output register and, in the drain, freezes the chain.
//   Reset empties the chain, clears the drop flag and the output valid flag.
// ---------------------------------------------------------------------------
`default_nettype none

module insertion_sort_engine_core #(
  parameter int MAX_ITEMS = ise_pkg::ISE_MAX_ITEMS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ise_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ise_pkg::out_word_t out_data
);

  ise_pkg::sort_state_t state_r;
  ise_pkg::sort_state_t state_nxt;
  ise_pkg::cell_ctrl_t  ctrl;
  ise_pkg::out_word_t   out_data_r;
  ise_pkg::out_word_t   out_data_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic                 dropped_r;
  logic                 dropped_nxt;
  logic                 in_take;
  logic                 full;
  logic                 out_load;

  logic signed [ise_pkg::VALUE_W-1:0] cell_value [MAX_ITEMS];
  logic                              cell_valid [MAX_ITEMS];
  logic                              cell_grt   [MAX_ITEMS];

  assign in_take = in_valid && !in_stall;
  assign full    = cell_valid[MAX_ITEMS-1];

  assign ctrl.ins_en    = in_take && !full;
  assign ctrl.shift_en  = out_load;
  assign ctrl.ins_value = in_data.value;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic                              l_valid;
    logic                              l_grt;
    logic signed [ise_pkg::VALUE_W-1:0] l_value;
    logic                              r_valid;
    logic signed [ise_pkg::VALUE_W-1:0] r_value;

    if (i == 0) begin : g_head
      assign l_valid = 1'b1;
      assign l_grt   = 1'b0;
      assign l_value = '0;
    end else begin : g_mid
      assign l_valid = cell_valid[i-1];
      assign l_grt   = cell_grt[i-1];
      assign l_value = cell_value[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_value = '0;
    end else begin : g_body
      assign r_valid = cell_valid[i+1];
      assign r_value = cell_value[i+1];
    end

    ise_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .left_valid  (l_valid),
      .left_grt    (l_grt),
      .left_value  (l_value),
      .right_valid (r_valid),
      .right_value (r_value),
      .cell_value  (cell_value[i]),
      .cell_valid  (cell_valid[i]),
      .cell_grt    (cell_grt[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    in_stall      = 1'b0;
    out_load      = 1'b0;
    dropped_nxt   = dropped_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      ise_pkg::SORT_LOAD: begin
        if (in_take && full) begin
          dropped_nxt = 1'b1;
        end
        if (in_take && in_data.last_in) begin
          state_nxt = ise_pkg::SORT_DRAIN;
        end
      end
      ise_pkg::SORT_DRAIN: begin
        in_stall = 1'b1;
        out_load = !out_valid_r || !out_stall;
        if (out_load) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.sorted_value = cell_value[0];
          out_data_nxt.last_out     = !cell_valid[1];
          out_data_nxt.overflow     = dropped_r;
          if (!cell_valid[1]) begin
            state_nxt   = ise_pkg::SORT_LOAD;
            dropped_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ise_pkg::SORT_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ise_pkg::SORT_LOAD;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/ise_checker.sv =====
// ---------------------------------------------------------------------------
// ise_checker
// Port-level checks of the insertion sort engine, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "insertion_sort_engine_core_assert.svh"

module ise_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input ise_pkg::in_word_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input ise_pkg::out_word_t out_data
);

  `ISE_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "out word not held while stalled")
  `ISE_ASSERT(a_last_stalls, in_valid && !in_stall && in_data.last_in |=> in_stall, "input not stalled after last word of set")
  `ISE_ASSERT(a_out_from_drain, $rose(out_valid) |-> $past(in_stall), "result appeared outside a drain")
  `ISE_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid && !in_stall, "block not idle after reset")

endmodule

bind insertion_sort_engine_core ise_checker u_ise_checker (.*);

`default_nettype wire
